>>> rtl/vmpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vmpt_pkg;

    localparam int MAX_OBJECTS_DEF = 16;
    localparam int ETA_SPAN_DEF    = 21;

    localparam int ENERGY_W = 12;
    localparam int CUT_W    = 6;
    localparam int VCUT_W   = 17;
    localparam int Z_W      = 16;
    localparam int ETA_W    = 5;
    localparam int BX_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_LEG_ONE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEG_TWO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_CUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_CUT = 2'd3;

    localparam logic [ENERGY_W-1:0] LEG_ONE_RST    = 12'd80;
    localparam logic [ENERGY_W-1:0] LEG_TWO_RST    = 12'd80;
    localparam logic [CUT_W-1:0]    REGION_CUT_RST = 6'd9;
    localparam logic [VCUT_W-1:0]   VERTEX_CUT_RST = 17'd65536;

    localparam int FLAG_WINDOW  = 0;
    localparam int FLAG_LEG_ONE = 1;
    localparam int FLAG_LEG_TWO = 2;

    typedef struct packed {
        logic [2:0]            flags;
        logic signed [Z_W-1:0] z;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/vertex_matched_pair_trigger.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_stall    object_valid zero_bias crossing eta_index
//                                             energy vertex_z last_object
// out       source     out_valid / out_stall  accept overflow
// cfg       sink       cfg_valid / cfg_ready  cfg_index cfg_data
//
// Non-last requests load one per cycle while idle. A last request starts the pair search:
// a read of object i, then a scan over candidates j through the store's one read port
// and the shared vertex compare, ending at the first matching pair.
// Reset is asynchronous; the store contents are not cleared.
// in_stall is high for the whole search; a pending result does not block loading.

module vertex_matched_pair_trigger #(
    parameter int MAX_OBJECTS = vmpt_pkg::MAX_OBJECTS_DEF,
    parameter int ETA_SPAN    = vmpt_pkg::ETA_SPAN_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output      logic                                in_stall,
    input  wire logic                                object_valid,
    input  wire logic                                zero_bias,
    input  wire logic signed [vmpt_pkg::BX_W-1:0]    crossing,
    input  wire logic [vmpt_pkg::ETA_W-1:0]          eta_index,
    input  wire logic [vmpt_pkg::ENERGY_W-1:0]       energy,
    input  wire logic signed [vmpt_pkg::Z_W-1:0]     vertex_z,
    input  wire logic                                last_object,
    output      logic                                out_valid,
    input  wire logic                                out_stall,
    output      logic                                accept,
    output      logic                                overflow,
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [vmpt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [vmpt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(MAX_OBJECTS);
    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OBJECTS);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
    localparam logic [6:0]       SPAN2   = 7'(2 * ETA_SPAN);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD_I  = 3'd1;
    localparam logic [2:0] S_GET_I = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             ovf_reg, ovf_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic signed [vmpt_pkg::Z_W-1:0] zi_reg, zi_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept_reg, accept_next;
    logic             overflow_reg, overflow_next;

    logic [vmpt_pkg::ENERGY_W-1:0] leg_one_reg, leg_two_reg;
    logic [vmpt_pkg::CUT_W-1:0]    region_cut_reg;
    logic [vmpt_pkg::VCUT_W-1:0]   vertex_cut_reg;

    logic             in_acc;
    logic             full;
    logic             wr_en;
    vmpt_pkg::entry_t wr_entry;
    logic [IDX_W-1:0] rd_addr;
    vmpt_pkg::entry_t rd_entry;
    logic [6:0]       eta2;
    logic             in_window;
    logic signed [vmpt_pkg::Z_W:0] dz;
    logic [vmpt_pkg::Z_W:0]        adz;
    logic             dz_ok;
    logic             leg_one_ok;
    logic             leg_two_ok;
    logic             i_last;
    logic             j_last;
    logic             out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign full      = (count_reg >= CNT_MAX);
    assign wr_en     = in_acc && object_valid && !full;

    assign eta2      = {1'b0, eta_index, 1'b0};
    assign in_window = (crossing == '0) && (eta2 >= 7'(region_cut_reg))
                       && ((eta2 + 7'(region_cut_reg)) <= SPAN2);

    always_comb
    begin
        wr_entry.z     = vertex_z;
        wr_entry.flags = '0;
        wr_entry.flags[vmpt_pkg::FLAG_WINDOW]  = in_window;
        wr_entry.flags[vmpt_pkg::FLAG_LEG_ONE] = (energy >= leg_one_reg);
        wr_entry.flags[vmpt_pkg::FLAG_LEG_TWO] = (energy >= leg_two_reg);
    end

    vmpt_store #(
        .DEPTH (MAX_OBJECTS)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (count_reg[IDX_W-1:0]),
        .wr_entry (wr_entry),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    // shared vertex compare: |zi - zj| < cut
    assign dz    = {zi_reg[vmpt_pkg::Z_W-1], zi_reg} - {rd_entry.z[vmpt_pkg::Z_W-1], rd_entry.z};
    assign adz   = dz[vmpt_pkg::Z_W] ? (vmpt_pkg::Z_W+1)'(-dz) : (vmpt_pkg::Z_W+1)'(dz);
    assign dz_ok = (adz < vertex_cut_reg);

    assign leg_one_ok = rd_entry.flags[vmpt_pkg::FLAG_WINDOW]
                        && rd_entry.flags[vmpt_pkg::FLAG_LEG_ONE];
    assign leg_two_ok = rd_entry.flags[vmpt_pkg::FLAG_WINDOW]
                        && rd_entry.flags[vmpt_pkg::FLAG_LEG_TWO];
    assign i_last     = ((CNT_W'(i_reg) + 1'b1) == n_reg);
    assign j_last     = ((CNT_W'(j_reg) + 1'b1) == n_reg);
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        n_next         = n_reg;
        ovf_next       = ovf_reg;
        found_next     = found_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        zi_next        = zi_reg;
        rd_addr        = i_reg;
        out_valid_next = out_valid_reg && out_stall;
        accept_next    = accept_reg;
        overflow_next  = overflow_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (last_object)
                    begin
                        n_next       = count_reg + CNT_W'(wr_en);
                        ovf_next     = dropped_reg || (object_valid && full);
                        found_next   = 1'b0;
                        i_next       = '0;
                        count_next   = '0;
                        dropped_next = 1'b0;
                        if (zero_bias && (n_next >= CNT_TWO))
                        begin
                            state_next = S_RD_I;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        count_next   = count_reg + CNT_W'(wr_en);
                        dropped_next = dropped_reg || (object_valid && full);
                    end
                end
            end
            S_RD_I:
            begin
                rd_addr    = i_reg;
                state_next = S_GET_I;
            end
            S_GET_I:
            begin
                zi_next = rd_entry.z;
                if (leg_one_ok)
                begin
                    j_next     = '0;
                    rd_addr    = '0;
                    state_next = S_SCAN;
                end
                else if (i_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    i_next  = i_reg + 1'b1;
                    rd_addr = i_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                if ((j_reg != i_reg) && leg_two_ok && dz_ok)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (j_last)
                begin
                    if (i_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        rd_addr    = i_reg + 1'b1;
                        state_next = S_GET_I;
                    end
                end
                else
                begin
                    j_next  = j_reg + 1'b1;
                    rd_addr = j_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    accept_next    = found_reg;
                    overflow_next  = ovf_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            leg_one_reg    <= vmpt_pkg::LEG_ONE_RST;
            leg_two_reg    <= vmpt_pkg::LEG_TWO_RST;
            region_cut_reg <= vmpt_pkg::REGION_CUT_RST;
            vertex_cut_reg <= vmpt_pkg::VERTEX_CUT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    vmpt_pkg::REG_LEG_ONE:    leg_one_reg    <= cfg_data[vmpt_pkg::ENERGY_W-1:0];
                    vmpt_pkg::REG_LEG_TWO:    leg_two_reg    <= cfg_data[vmpt_pkg::ENERGY_W-1:0];
                    vmpt_pkg::REG_REGION_CUT: region_cut_reg <= cfg_data[vmpt_pkg::CUT_W-1:0];
                    vmpt_pkg::REG_VERTEX_CUT: vertex_cut_reg <= cfg_data[vmpt_pkg::VCUT_W-1:0];
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        ovf_reg      <= ovf_next;
        found_reg    <= found_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        zi_reg       <= zi_next;
        accept_reg   <= accept_next;
        overflow_reg <= overflow_next;
    end

    assign out_valid = out_valid_reg;
    assign accept    = accept_reg;
    assign overflow  = overflow_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("object count above capacity");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((CNT_W'(j_reg) < n_reg) && (CNT_W'(i_reg) < n_reg)))
        else $error("scan index outside stored objects");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside done state");
`endif

endmodule

`default_nettype wire

>>> rtl/vmpt_store.sv
`timescale 1ns / 1ps
`default_nettype none

module vmpt_store #(
    parameter int DEPTH = vmpt_pkg::MAX_OBJECTS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire vmpt_pkg::entry_t         wr_entry,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output vmpt_pkg::entry_t              rd_entry
);

    vmpt_pkg::entry_t mem [DEPTH];
    vmpt_pkg::entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import vmpt_pkg::*;

    localparam int N_SLOTS       = MAX_OBJECTS_DEF;
    localparam int ETA_SPAN      = ETA_SPAN_DEF;
    localparam int EVENT_SETTLE  = 8;
    localparam int FINAL_SETTLE  = N_SLOTS * (N_SLOTS + 1) + 2 + 16;
    localparam int PHASE_ITEMS   = 170;
    localparam int PRESSURE_EVERY = 37;

    typedef struct packed {
        logic                  object_valid;
        logic                  zero_bias;
        logic signed [BX_W-1:0] crossing;
        logic [ETA_W-1:0]      eta_index;
        logic [ENERGY_W-1:0]   energy;
        logic signed [Z_W-1:0] vertex_z;
        logic                  last_object;
    } tau_req_t;

    typedef struct packed {
        logic accept;
        logic overflow;
    } decision_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic object_valid;
    logic zero_bias;
    logic signed [BX_W-1:0] crossing;
    logic [ETA_W-1:0] eta_index;
    logic [ENERGY_W-1:0] energy;
    logic signed [Z_W-1:0] vertex_z;
    logic last_object;
    logic out_valid;
    logic out_stall;
    logic accept;
    logic overflow;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // trigger model state
    logic [ENERGY_W-1:0] leg_one_min = LEG_ONE_RST;
    logic [ENERGY_W-1:0] leg_two_min = LEG_TWO_RST;
    logic [CUT_W-1:0]    eta_margin  = REGION_CUT_RST;
    logic [VCUT_W-1:0]   dz_limit    = VERTEX_CUT_RST;
    logic signed [Z_W-1:0] held_z [N_SLOTS];
    logic [2:0]            held_flags [N_SLOTS];
    int                    held_count = 0;
    bit                    held_dropped = 1'b0;

    decision_t pending_decisions [$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int requests_sent = 0;
    int decisions_seen = 0;
    int accepts_seen = 0;
    int overflows_seen = 0;
    int settings_used = 0;
    int mismatches = 0;

    vertex_matched_pair_trigger uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .object_valid (object_valid),
        .zero_bias    (zero_bias),
        .crossing     (crossing),
        .eta_index    (eta_index),
        .energy       (energy),
        .vertex_z     (vertex_z),
        .last_object  (last_object),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accept       (accept),
        .overflow     (overflow),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    function automatic bit pair_in_store();
        int d;
        for (int i = 0; i < held_count; i++)
        begin
            if (!(held_flags[i][FLAG_WINDOW] && held_flags[i][FLAG_LEG_ONE]))
                continue;
            for (int j = 0; j < held_count; j++)
            begin
                if (j == i || !(held_flags[j][FLAG_WINDOW] && held_flags[j][FLAG_LEG_TWO]))
                    continue;
                d = int'(held_z[i]) - int'(held_z[j]);
                if (d < 0)
                    d = -d;
                if (d < int'(dz_limit))
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void absorb_request(input tau_req_t r);
        decision_t d;
        logic [2:0] f;
        int eta2;
        int cut;
        if (r.object_valid)
        begin
            if (held_count < N_SLOTS)
            begin
                eta2 = 2 * int'(r.eta_index);
                cut = int'(eta_margin);
                f = '0;
                f[FLAG_WINDOW]  = (r.crossing == 0) && (eta2 >= cut)
                                  && (eta2 <= 2 * ETA_SPAN - cut);
                f[FLAG_LEG_ONE] = (r.energy >= leg_one_min);
                f[FLAG_LEG_TWO] = (r.energy >= leg_two_min);
                held_z[held_count] = r.vertex_z;
                held_flags[held_count] = f;
                held_count++;
            end
            else
                held_dropped = 1'b1;
        end
        if (r.last_object)
        begin
            d.accept = r.zero_bias && pair_in_store();
            d.overflow = held_dropped;
            pending_decisions = {pending_decisions, d};
            held_count = 0;
            held_dropped = 1'b0;
        end
    endfunction

    function automatic tau_req_t candidate(input logic signed [BX_W-1:0] bx,
                                           input logic [ETA_W-1:0] eta,
                                           input logic [ENERGY_W-1:0] et,
                                           input logic signed [Z_W-1:0] z,
                                           input logic zb, input logic last);
        return '{1'b1, zb, bx, eta, et, z, last};
    endfunction

    function automatic tau_req_t no_candidate(input logic zb, input logic last);
        return '{1'b0, zb, 4'sd0, 5'd0, 12'd0, 16'sd0, last};
    endfunction

    // leaves in_valid high; whoever stops sending lowers it
    task automatic send_request(input tau_req_t r);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_valid     <= 1'b1;
        object_valid <= r.object_valid;
        zero_bias    <= r.zero_bias;
        crossing     <= r.crossing;
        eta_index    <= r.eta_index;
        energy       <= r.energy;
        vertex_z     <= r.vertex_z;
        last_object  <= r.last_object;
        do @(posedge clk); while (in_stall);
        absorb_request(r);
        requests_sent++;
    endtask

    task automatic drain_decisions(input int settle);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_decisions.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_LEG_ONE:    leg_one_min = data[ENERGY_W-1:0];
            REG_LEG_TWO:    leg_two_min = data[ENERGY_W-1:0];
            REG_REGION_CUT: eta_margin  = data[CUT_W-1:0];
            REG_VERTEX_CUT: dz_limit    = data[VCUT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int l1, input int l2, input int cut, input int vcut);
        drain_decisions(EVENT_SETTLE);
        write_reg(REG_LEG_ONE, CFG_DATA_W'(l1));
        write_reg(REG_LEG_TWO, CFG_DATA_W'(l2));
        write_reg(REG_REGION_CUT, CFG_DATA_W'(cut));
        write_reg(REG_VERTEX_CUT, CFG_DATA_W'(vcut));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic random_event();
        int n;
        int sel;
        int spread;
        logic [Z_W-1:0] base;
        bit tail_marker;
        tau_req_t r;
        sel = $urandom_range(99);
        if (sel < 80)
            n = $urandom_range(5);
        else if (sel < 95)
            n = $urandom_range(15, 6);
        else
            n = $urandom_range(20, 16);
        base = Z_W'($urandom);
        spread = $urandom_range(1) ? 300 : 3000;
        tail_marker = (n == 0) || ($urandom_range(9) == 0);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(19) == 0)
                send_request(no_candidate(1'($urandom), 1'b0));
            r.object_valid = 1'b1;
            r.zero_bias = 1'($urandom);
            r.crossing = ($urandom_range(4) != 0) ? 4'sd0 : BX_W'($urandom);
            r.eta_index = ($urandom_range(3) != 0) ? ETA_W'($urandom_range(18, 3))
                                                   : ETA_W'($urandom);
            r.energy = ($urandom_range(2) != 0) ? ENERGY_W'($urandom_range(255))
                                                : ENERGY_W'($urandom);
            r.vertex_z = ($urandom_range(3) != 0)
                ? base + Z_W'($urandom_range(2 * spread)) - Z_W'(spread)
                : Z_W'($urandom);
            r.last_object = (k == n - 1) && !tail_marker;
            if (r.last_object)
                r.zero_bias = ($urandom_range(6) != 0);
            send_request(r);
        end
        if (tail_marker)
            send_request(no_candidate(($urandom_range(6) != 0), 1'b1));
    endtask

    always @(posedge clk)
    begin
        decision_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_decisions.size() == 0)
            begin
                $error("unexpected result: accept=%0b overflow=%0b", accept, overflow);
                mismatches++;
            end
            else
            begin
                want = pending_decisions.pop_front();
                if (accept !== want.accept)
                begin
                    $error("accept: expected %0b, got %0b", want.accept, accept);
                    mismatches++;
                end
                if (overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b", want.overflow, overflow);
                    mismatches++;
                end
                decisions_seen++;
                accepts_seen += want.accept;
                overflows_seen += want.overflow;
            end
        end
    end

    task automatic test_reset_values();
        send_request(candidate(0, 5, 80, -32768, 1'b1, 1'b0));
        send_request(candidate(0, 16, 4095, 32767, 1'b1, 1'b1));
        send_request(no_candidate(1'b1, 1'b1));
        send_request(candidate(0, 10, 100, 5, 1'b0, 1'b0));
        send_request(candidate(0, 11, 100, 5, 1'b0, 1'b1));
        send_request(candidate(-8, 0, 4095, 0, 1'b1, 1'b0));
        send_request(candidate(7, 31, 4095, 0, 1'b1, 1'b1));
    endtask

    task automatic test_store_overflow();
        for (int k = 0; k <= N_SLOTS; k++)
            send_request(candidate(0, 10, 100, Z_W'(k * 7), 1'b1, k == N_SLOTS));
        send_request(candidate(0, 10, 100, 0, 1'b1, 1'b1));
    endtask

    task automatic test_register_extremes();
        set_config(4095, 4095, 42, 0);
        send_request(candidate(0, 21, 4095, 100, 1'b1, 1'b0));
        send_request(candidate(0, 21, 4095, 100, 1'b1, 1'b1));
        // margin wider than the whole eta range
        set_config(0, 0, 50, 65536);
        send_request(candidate(0, 10, 0, 0, 1'b1, 1'b0));
        send_request(candidate(0, 12, 0, 0, 1'b1, 1'b1));
        set_config(0, 0, 0, 1);
        send_request(candidate(0, 0, 0, 0, 1'b1, 1'b0));
        send_request(candidate(0, 21, 0, 0, 1'b1, 1'b1));
    endtask

    task automatic test_random_traffic(input int sender_pct, input int stall_pct, input int phases);
        int goal;
        int events;
        src_idle_pct = sender_pct;
        sink_stall_pct = stall_pct;
        for (int p = 0; p < phases; p++)
        begin
            case ($urandom_range(3))
                0: set_config($urandom_range(200), $urandom_range(200), $urandom_range(20),
                              $urandom_range(100));
                1: set_config($urandom_range(200), $urandom_range(200), $urandom_range(20),
                              $urandom_range(2000, 100));
                2: set_config($urandom_range(200), $urandom_range(200), $urandom_range(42),
                              65536);
                default: set_config($urandom_range(4095), $urandom_range(4095),
                                    $urandom_range(20), $urandom_range(65536));
            endcase
            goal = requests_sent + PHASE_ITEMS;
            events = 0;
            while (requests_sent < goal)
            begin
                random_event();
                events++;
                if (events % PRESSURE_EVERY == 0)
                    drain_decisions(0);
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        object_valid = 1'b0;
        zero_bias    = 1'b0;
        crossing     = '0;
        eta_index    = '0;
        energy       = '0;
        vertex_z     = '0;
        last_object  = 1'b0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_LEG_ONE;
        cfg_data     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_store_overflow();
        test_register_extremes();
        test_random_traffic(16, 72, 3);
        test_random_traffic(72, 16, 3);
        test_random_traffic(0, 0, 3);
        drain_decisions(FINAL_SETTLE);

        $display("Sent %0d tau requests under %0d register settings and three idle mixes.",
                 requests_sent, settings_used);
        $display("Checked %0d event decisions: %0d fired, %0d reported dropped candidates.",
                 decisions_seen, accepts_seen, overflows_seen);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
